// ===== hw/rtl/bpks_pkg.sv =====
// Shared definitions for the block-partitioned key store.
// Holds parameter defaults, request and status codes, and the memory command struct.
// No dependencies.
package bpks_pkg;

	localparam int NUM_BLOCKS_DEF  = 8;
	localparam int BLOCK_SLOTS_DEF = 256;
	localparam int KEY_BITS_DEF    = 32;

	// Fixed widths of the request and result fields.
	localparam int BLOCK_NUM_W = 3;
	localparam int KEY_IN_W    = 32;
	localparam int SLOT_OUT_W  = 11;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_FIND   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// Per-cycle enables from the sequencer to the two memories.
	typedef struct packed {
		logic fill_rd;
		logic fill_wr;
		logic key_rd;
		logic key_wr;
	} mem_cmd_t;

endpackage

// ===== hw/rtl/bpks_fill_mem.sv =====
// Fill count memory: one count per block, one read and one write port.
// Each entry has a valid bit that reset clears, so an unwritten count reads as zero.
// Depends on bpks_pkg.
module bpks_fill_mem #(
	parameter int NUM_BLOCKS = bpks_pkg::NUM_BLOCKS_DEF,
	parameter int BLK_W      = 3,
	parameter int FILL_W     = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpks_pkg::mem_cmd_t   cmd,
	input  logic [BLK_W-1:0]     rd_addr,
	input  logic [BLK_W-1:0]     wr_addr,
	input  logic [FILL_W-1:0]    wr_data,
	output logic [FILL_W-1:0]    rd_data
);

	logic [FILL_W-1:0]     mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;
	logic [FILL_W-1:0]     rd_data_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.fill_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.fill_rd) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/bpks_key_mem.sv =====
// Key memory: all slots of all blocks, one write and one registered read port.
// Entries are undefined until written; the sequencer reads only filled slots.
// Depends on bpks_pkg.
module bpks_key_mem #(
	parameter int DEPTH  = bpks_pkg::NUM_BLOCKS_DEF * bpks_pkg::BLOCK_SLOTS_DEF,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 32
) (
	input  logic                clk,
	input  bpks_pkg::mem_cmd_t  cmd,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [DATA_W-1:0]   wr_data,
	output logic [DATA_W-1:0]   rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.key_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.key_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bpks_ctrl.sv =====
// Sequencer for inserts and finds: issues memory reads, compares, writes back.
// Holds the result registers and the done strobe.
// Depends on bpks_pkg.
module bpks_ctrl #(
	parameter int NUM_BLOCKS  = bpks_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_SLOTS = bpks_pkg::BLOCK_SLOTS_DEF,
	parameter int BLK_W       = 3,
	parameter int FILL_W      = 9,
	parameter int ADDR_W      = 11,
	parameter int SB          = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               req_type,
	input  logic [bpks_pkg::BLOCK_NUM_W-1:0]   block_number,
	input  logic [bpks_pkg::KEY_IN_W-1:0]      key_value,
	output logic                               busy,
	output logic                               done,
	output bpks_pkg::status_t                  status,
	output logic [bpks_pkg::SLOT_OUT_W-1:0]    slot_index,
	output bpks_pkg::mem_cmd_t                 cmd,
	output logic [BLK_W-1:0]                   fill_rd_addr,
	output logic [BLK_W-1:0]                   fill_wr_addr,
	output logic [FILL_W-1:0]                  fill_wr_data,
	input  logic [FILL_W-1:0]                  fill_rd_data,
	output logic [ADDR_W-1:0]                  key_rd_addr,
	output logic [ADDR_W-1:0]                  key_wr_addr,
	output logic [SB-1:0]                      key_wr_data,
	input  logic [SB-1:0]                      key_rd_data
);

	localparam int BN_W  = bpks_pkg::BLOCK_NUM_W;
	localparam int OUT_W = bpks_pkg::SLOT_OUT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_FILL,
		S_WALK
	} state_t;

	state_t              state_q;
	logic [BLK_W-1:0]    blk_q;
	logic [SB-1:0]       key_q;
	logic [ADDR_W-1:0]   base_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   j_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   paddr_s1;
	logic                done_q;
	bpks_pkg::status_t   status_q;
	logic [OUT_W-1:0]    slot_q;

	logic                   accept;
	logic [BLK_W+BN_W-1:0]  blk_ext;
	logic [BLK_W-1:0]       blk_idx;
	logic                   blk_oob;
	logic [ADDR_W-1:0]      base_ins;
	logic [ADDR_W+FILL_W-1:0] walk_sum;
	logic [ADDR_W+FILL_W-1:0] ins_sum;
	logic [ADDR_W-1:0]      walk_addr;
	logic [ADDR_W-1:0]      ins_addr;
	logic                   has_room;
	logic                   hit;
	logic                   more;
	logic                   last_blk;
	logic [BLK_W-1:0]       blk_nxt;

	// Global slot index cut or widened to the result field.
	function automatic logic [OUT_W-1:0] to_slot(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W+OUT_W-1:0] ext;
		ext = {{OUT_W{1'b0}}, addr};
		return ext[OUT_W-1:0];
	endfunction

	assign accept   = start && (state_q == S_IDLE);
	assign blk_ext  = {{BLK_W{1'b0}}, block_number};
	assign blk_idx  = blk_ext[BLK_W-1:0];
	assign blk_oob  = blk_ext >= (BLK_W+BN_W)'(NUM_BLOCKS);
	assign base_ins = ADDR_W'(int'(blk_idx) * BLOCK_SLOTS);

	assign walk_sum  = {{FILL_W{1'b0}}, base_q} + {{ADDR_W{1'b0}}, j_q};
	assign ins_sum   = {{FILL_W{1'b0}}, base_q} + {{ADDR_W{1'b0}}, fill_rd_data};
	assign walk_addr = walk_sum[ADDR_W-1:0];
	assign ins_addr  = ins_sum[ADDR_W-1:0];

	assign has_room = fill_rd_data < FILL_W'(BLOCK_SLOTS);
	assign hit      = pend_s1 && (key_rd_data == key_q);
	assign more     = j_q < fill_q;
	assign last_blk = blk_q == BLK_W'(NUM_BLOCKS - 1);
	assign blk_nxt  = blk_q + BLK_W'(1);

	always_comb begin
		cmd.fill_rd = (accept && ((req_type == bpks_pkg::REQ_FIND) || !blk_oob))
			|| ((state_q == S_WALK) && !hit && !more && !last_blk);
		cmd.fill_wr = (state_q == S_INS) && has_room;
		cmd.key_wr  = (state_q == S_INS) && has_room;
		cmd.key_rd  = (state_q == S_WALK) && !hit && more;
	end

	assign fill_rd_addr = accept ? ((req_type == bpks_pkg::REQ_FIND) ? '0 : blk_idx) : blk_nxt;
	assign fill_wr_addr = blk_q;
	assign fill_wr_data = fill_rd_data + FILL_W'(1);
	assign key_wr_addr  = ins_addr;
	assign key_wr_data  = key_q;
	assign key_rd_addr  = walk_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			pend_s1  <= 1'b0;
			blk_q    <= '0;
			key_q    <= '0;
			base_q   <= '0;
			fill_q   <= '0;
			j_q      <= '0;
			paddr_s1 <= '0;
			status_q <= bpks_pkg::ST_OK;
			slot_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= key_value[SB-1:0];
						if (req_type == bpks_pkg::REQ_FIND) begin
							blk_q   <= '0;
							base_q  <= '0;
							state_q <= S_FILL;
						end else if (blk_oob) begin
							done_q   <= 1'b1;
							status_q <= bpks_pkg::ST_FULL;
							slot_q   <= '0;
						end else begin
							blk_q   <= blk_idx;
							base_q  <= base_ins;
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (has_room) begin
						status_q <= bpks_pkg::ST_OK;
						slot_q   <= to_slot(ins_addr);
					end else begin
						status_q <= bpks_pkg::ST_FULL;
						slot_q   <= '0;
					end
				end
				S_FILL: begin
					fill_q  <= fill_rd_data;
					j_q     <= '0;
					pend_s1 <= 1'b0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (hit) begin
						pend_s1  <= 1'b0;
						done_q   <= 1'b1;
						status_q <= bpks_pkg::ST_OK;
						slot_q   <= to_slot(paddr_s1);
						state_q  <= S_IDLE;
					end else if (more) begin
						pend_s1  <= 1'b1;
						paddr_s1 <= walk_addr;
						j_q      <= j_q + FILL_W'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (last_blk) begin
							done_q   <= 1'b1;
							status_q <= bpks_pkg::ST_MISSING;
							slot_q   <= '0;
							state_q  <= S_IDLE;
						end else begin
							blk_q   <= blk_nxt;
							base_q  <= base_q + ADDR_W'(BLOCK_SLOTS);
							state_q <= S_FILL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;

endmodule

// ===== hw/rtl/block_partitioned_key_store_top.sv =====
// Block-partitioned key store, top level. An insert's result is strobed once the sequencer
// leaves S_INS, an insert naming a nonexistent block in the cycle after its transfer.
// A find reads each block's fill count and then its filled slots until a hit, paced by the single read
// port of the key memory, which delivers one stored key per cycle while a block is walked; busy blocks new requests.
// Reset (arst_n low) clears all fill counts at once; keys stay undefined until written.
// Results are shown for one cycle with done and cannot be stalled by the receiver.
module block_partitioned_key_store_top #(
	parameter int NUM_BLOCKS  = bpks_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_SLOTS = bpks_pkg::BLOCK_SLOTS_DEF,
	parameter int KEY_BITS    = bpks_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [bpks_pkg::BLOCK_NUM_W-1:0]   block_number,
	input  logic signed [bpks_pkg::KEY_IN_W-1:0] key_value,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [bpks_pkg::SLOT_OUT_W-1:0]    slot_index
);

	// Derived sizes. Keys are kept in their low KEY_BITS bits; beyond the 32 bits of the
	// request field the upper bits would always be zero, so storage stops at 32.
	localparam int TOTAL  = NUM_BLOCKS * BLOCK_SLOTS;
	localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int FILL_W = $clog2(BLOCK_SLOTS + 1);
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SB     = (KEY_BITS < bpks_pkg::KEY_IN_W) ? KEY_BITS : bpks_pkg::KEY_IN_W;

	bpks_pkg::mem_cmd_t  cmd;
	bpks_pkg::status_t   status_e;
	logic [BLK_W-1:0]    fill_rd_addr;
	logic [BLK_W-1:0]    fill_wr_addr;
	logic [FILL_W-1:0]   fill_wr_data;
	logic [FILL_W-1:0]   fill_rd_data;
	logic [ADDR_W-1:0]   key_rd_addr;
	logic [ADDR_W-1:0]   key_wr_addr;
	logic [SB-1:0]       key_wr_data;
	logic [SB-1:0]       key_rd_data;

	// The sequencer owns all control: it reads a block's fill count, then either writes
	// the key and the incremented count (insert) or walks the filled slots (find),
	// comparing each key in the cycle after its read was issued.
	bpks_ctrl #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_SLOTS (BLOCK_SLOTS),
		.BLK_W       (BLK_W),
		.FILL_W      (FILL_W),
		.ADDR_W      (ADDR_W),
		.SB          (SB)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.block_number (block_number),
		.key_value    (key_value),
		.busy         (busy),
		.done         (done),
		.status       (status_e),
		.slot_index   (slot_index),
		.cmd          (cmd),
		.fill_rd_addr (fill_rd_addr),
		.fill_wr_addr (fill_wr_addr),
		.fill_wr_data (fill_wr_data),
		.fill_rd_data (fill_rd_data),
		.key_rd_addr  (key_rd_addr),
		.key_wr_addr  (key_wr_addr),
		.key_wr_data  (key_wr_data),
		.key_rd_data  (key_rd_data)
	);

	// Fill counts. A count is written only in the cycle after its read and no other request
	// overlaps, so no forwarding path is needed.
	bpks_fill_mem #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.BLK_W      (BLK_W),
		.FILL_W     (FILL_W)
	) u_fill_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (fill_rd_addr),
		.wr_addr (fill_wr_addr),
		.wr_data (fill_wr_data),
		.rd_data (fill_rd_data)
	);

	// Stored keys, addressed by global slot index.
	bpks_key_mem #(
		.DEPTH  (TOTAL),
		.ADDR_W (ADDR_W),
		.DATA_W (SB)
	) u_key_mem (
		.clk     (clk),
		.cmd     (cmd),
		.rd_addr (key_rd_addr),
		.wr_addr (key_wr_addr),
		.wr_data (key_wr_data),
		.rd_data (key_rd_data)
	);

	assign status = status_e;

	// A result always ends the request, so the block is free in the cycle it is shown.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while a request is still in progress");

	// Error results carry a zero slot index.
	a_error_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_e != bpks_pkg::ST_OK)) |-> (slot_index == '0))
		else $error("error result with nonzero slot index");

	// A find always needs at least a fill read, so it cannot finish at its own transfer.
	a_find_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == bpks_pkg::REQ_FIND)) |=> (busy && !done))
		else $error("find finished without walking the table");

	// A memory write happens only while an insert is in progress.
	a_write_in_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.key_wr || cmd.fill_wr) |-> (busy && !cmd.key_rd))
		else $error("memory write outside an insert");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_partitioned_key_store_top: insert and find requests
// are checked against an in-bench model of the fill counts and the stored keys.
// Depends on bpks_pkg and the RTL of the key store; needs nothing else.
module testbench;
	import bpks_pkg::*;

	localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
	localparam int BLOCK_SLOTS  = BLOCK_SLOTS_DEF;
	localparam int TOTAL_SLOTS  = NUM_BLOCKS * BLOCK_SLOTS;
	localparam int RANDOM_ITEMS = 290;
	localparam int AFTER_FULL   = 12;
	localparam int SETTLE_WAIT  = 20;
	// A find that misses scans every filled slot of every block at one key per cycle.
	// With all blocks full that is the worst case for a single transfer. About 350
	// transfers at that worst case plus the gaps between them stay well within
	// the limit below.
	localparam int LIMIT_CYCLES = 3_000_000;

	typedef struct {
		logic                   kind;
		logic [BLOCK_NUM_W-1:0] blk;
		logic [KEY_IN_W-1:0]    key;
		bit                     drain;
	} request_t;

	typedef struct {
		status_t                stat;
		logic [SLOT_OUT_W-1:0]  slot;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          req_type = REQ_INSERT;
	logic [BLOCK_NUM_W-1:0]        block_number = '0;
	logic signed [KEY_IN_W-1:0]    key_value = '0;
	logic                          done;
	logic [1:0]                    status;
	logic [SLOT_OUT_W-1:0]         slot_index;

	// Requests waiting to be sent, and the outcomes waiting to be strobed back.
	request_t pending_requests[$];
	outcome_t awaited_outcomes[$];

	// Model state: fill count per block and the keys written so far.
	int unsigned      model_fill[NUM_BLOCKS];
	logic [KEY_IN_W-1:0] model_keys[TOTAL_SLOTS];

	// Fill counts and keys as the stimulus generator sees them while it builds
	// the request list, so that it knows when the chosen block is full.
	int unsigned      plan_fill[NUM_BLOCKS];
	logic [KEY_IN_W-1:0] key_history[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;

	block_partitioned_key_store_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.block_number (block_number),
		.key_value    (key_value),
		.done         (done),
		.status       (status),
		.slot_index   (slot_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Computes what the store answers to one request and updates the model state.
	// An insert takes the next free slot of its block; a find returns the first
	// filled slot holding the key, scanning blocks and slots in ascending order.
	function automatic outcome_t lookup_outcome(logic kind, logic [BLOCK_NUM_W-1:0] blk,
			logic [KEY_IN_W-1:0] key);
		outcome_t    res;
		int unsigned slot;
		res.stat = ST_MISSING;
		res.slot = '0;
		if (kind == REQ_INSERT) begin
			res.stat = ST_FULL;
			if (int'(blk) < NUM_BLOCKS && model_fill[blk] < BLOCK_SLOTS) begin
				slot = blk * BLOCK_SLOTS + model_fill[blk];
				model_keys[slot] = key;
				model_fill[blk]++;
				res.stat = ST_OK;
				res.slot = slot[SLOT_OUT_W-1:0];
			end
		end else begin
			for (int b = 0; b < NUM_BLOCKS && res.stat != ST_OK; b++) begin
				for (int j = 0; j < model_fill[b] && res.stat != ST_OK; j++) begin
					if (model_keys[b * BLOCK_SLOTS + j] == key) begin
						slot = b * BLOCK_SLOTS + j;
						res.stat = ST_OK;
						res.slot = slot[SLOT_OUT_W-1:0];
					end
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Queues one request and tracks what the generator knows about the table.
	task automatic add_request(input logic kind, input int blk, input logic [31:0] key,
			input bit drain);
		request_t req;
		req.kind  = kind;
		req.blk   = blk[BLOCK_NUM_W-1:0];
		req.key   = key;
		req.drain = drain;
		pending_requests.insert(pending_requests.size(), req);
		if (kind == REQ_INSERT && plan_fill[blk] < BLOCK_SLOTS) begin
			plan_fill[blk]++;
			key_history.insert(key_history.size(), key);
		end
	endtask

	// Keys for random requests: random words, often a key already stored so
	// that finds hit and duplicates appear across blocks, and some corner values.
	function automatic logic [31:0] pick_key();
		int          roll;
		logic [31:0] one_bit;
		roll = $urandom_range(0, 9);
		one_bit = 32'd1 << $urandom_range(0, 31);
		if (roll <= 3 || (roll <= 6 && key_history.size() == 0))
			return $urandom;
		if (roll <= 6)
			return key_history[$urandom_range(0, key_history.size() - 1)];
		if (roll == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		if (roll == 8)
			return one_bit;
		return ~one_bit;
	endfunction

	// Driver: changes inputs on the falling edge. A presented request is held until
	// the monitor sees its transfer; in between, requests go out in bursts with
	// idle gaps, and a request marked drain waits until all outcomes are back.
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_requests.size() == 0) begin
				start <= 1'b0;
			end else if (pending_requests[0].drain && awaited_outcomes.size() != 0) begin
				start <= 1'b0;
			end else begin
				start        <= 1'b1;
				req_type     <= pending_requests[0].kind;
				block_number <= pending_requests[0].blk;
				key_value    <= pending_requests[0].key;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Monitor: samples on the rising edge. Any strobed outcome is checked against
	// the oldest awaited one before a new transfer adds its own expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result status=%0d slot=%0d",
						status, slot_index));
				end else begin
					want = awaited_outcomes.pop_front();
					if (status !== want.stat)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.stat));
					if (slot_index !== want.slot)
						report_mismatch($sformatf("slot_index %0d, expected %0d",
							slot_index, want.slot));
				end
			end
			if (start && !busy) begin
				awaited_outcomes.insert(awaited_outcomes.size(),
					lookup_outcome(req_type, block_number, key_value));
				void'(pending_requests.pop_front());
				taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int  hot;
		int  roll;
		int  count;
		int  after_full;
		bit  drain;

		for (int b = 0; b < NUM_BLOCKS; b++) begin
			model_fill[b] = 0;
			plan_fill[b] = 0;
		end

		// Directed part: a find on the empty table, extreme keys, duplicates in two
		// blocks (the lower block must win), absent keys and single-bit differences.
		add_request(REQ_FIND,   0, 32'h0000_0000, 1'b1);
		add_request(REQ_INSERT, 0, 32'h8000_0000, 1'b0);
		add_request(REQ_INSERT, 7, 32'h7FFF_FFFF, 1'b0);
		add_request(REQ_INSERT, 0, 32'h0000_0000, 1'b0);
		add_request(REQ_INSERT, 3, 32'hFFFF_FFFF, 1'b0);
		add_request(REQ_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
		add_request(REQ_FIND,   5, 32'h7FFF_FFFF, 1'b1);
		add_request(REQ_FIND,   7, 32'h8000_0000, 1'b0);
		add_request(REQ_FIND,   2, 32'h0000_0000, 1'b0);
		add_request(REQ_FIND,   0, 32'hFFFF_FFFF, 1'b0);
		add_request(REQ_FIND,   6, 32'h1234_5678, 1'b0);
		add_request(REQ_INSERT, 7, 32'h8000_0000, 1'b0);
		add_request(REQ_FIND,   1, 32'h8000_0000, 1'b0);
		add_request(REQ_INSERT, 2, 32'h5555_5555, 1'b0);
		add_request(REQ_INSERT, 2, 32'hAAAA_AAAA, 1'b0);
		add_request(REQ_FIND,   3, 32'hAAAA_AAAA, 1'b0);
		add_request(REQ_INSERT, 4, 32'h0000_0001, 1'b0);
		add_request(REQ_INSERT, 5, 32'h0000_0002, 1'b0);
		add_request(REQ_INSERT, 6, 32'h4000_0000, 1'b0);
		add_request(REQ_FIND,   4, 32'h4000_0000, 1'b0);
		add_request(REQ_FIND,   7, 32'h0000_0001, 1'b0);
		add_request(REQ_FIND,   0, 32'hFFFF_FFFE, 1'b1);

		// Random part: one block is filled to capacity while the rest take a few
		// inserts and finds run in between; once it is full, inserts keep aiming
		// at it so that the full status shows up several times.
		hot = $urandom_range(0, NUM_BLOCKS - 1);
		count = 0;
		after_full = 0;
		while (count < RANDOM_ITEMS || plan_fill[hot] < BLOCK_SLOTS
				|| after_full < AFTER_FULL) begin
			roll = $urandom_range(0, 99);
			drain = ($urandom_range(0, 49) == 0);
			if (roll < 80) begin
				if (plan_fill[hot] < BLOCK_SLOTS || $urandom_range(0, 1) == 0)
					add_request(REQ_INSERT, hot, pick_key(), drain);
				else
					add_request(REQ_INSERT, $urandom_range(0, NUM_BLOCKS - 1),
						pick_key(), drain);
			end else if (roll < 88) begin
				add_request(REQ_INSERT, $urandom_range(0, NUM_BLOCKS - 1), pick_key(), drain);
			end else begin
				add_request(REQ_FIND, $urandom_range(0, NUM_BLOCKS - 1), pick_key(), drain);
			end
			if (plan_fill[hot] >= BLOCK_SLOTS)
				after_full++;
			count++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
